@@ design/lci_pkg.sv @@
package lci_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROJ_COS       = 3'd0,
      CSR_PROJ_SIN       = 3'd1,
      CSR_STRETCH_GAIN   = 3'd2,
      CSR_STRETCH_OFFSET = 3'd3,
      CSR_CLAMP_FLOOR    = 3'd4,
      CSR_CLAMP_CEILING  = 3'd5
   } csr_index_type;

   typedef logic signed [14:0] coef_type;

   typedef struct packed {
      coef_type    proj_cos;
      coef_type    proj_sin;
      logic [7:0]  stretch_gain;
      logic [7:0]  stretch_offset;
      logic [7:0]  clamp_floor;
      logic [7:0]  clamp_ceiling;
   } cfg_type;

   localparam coef_type   RESET_PROJ_COS       = -15'sd10917;
   localparam coef_type   RESET_PROJ_SIN       = 15'sd12218;
   localparam logic [7:0] RESET_STRETCH_GAIN   = 8'd32;
   localparam logic [7:0] RESET_STRETCH_OFFSET = 8'd128;
   localparam logic [7:0] RESET_CLAMP_FLOOR    = 8'd10;
   localparam logic [7:0] RESET_CLAMP_CEILING  = 8'd245;

   // Matrix accumulator and color matrix magnitudes, Q1.14
   typedef logic signed [23:0] acc_type;
   localparam acc_type M_RR = 24'sd16364;
   localparam acc_type M_RG = 24'sd1096;
   localparam acc_type M_RB = 24'sd2;
   localparam acc_type M_GR = 24'sd814;
   localparam acc_type M_GG = 24'sd16197;
   localparam acc_type M_GB = 24'sd2;
   localparam acc_type M_BR = 24'sd70;
   localparam acc_type M_BG = 24'sd2205;
   localparam acc_type M_BB = 24'sd16384;
   localparam acc_type ACC_ROUND = 24'sd8192;

   // ln(x) in Q3.12 for x = 1..255
   typedef logic [14:0] ln_word_type;
   typedef ln_word_type [255:0] ln_table_type;
   typedef logic signed [16:0] chi_type;
   typedef logic signed [31:0] proj_type;
   typedef logic signed [41:0] scaled_type;

   localparam int          LOG_INDEX_BITS = 10;
   localparam logic [63:0] LN2_Q12        = 64'd2839;
   localparam logic [63:0] LN2_Q30        = 64'd744261118;

   function automatic ln_table_type build_ln_table();
      ln_table_type tbl;
      logic [8:0]   x;
      logic [63:0]  z;
      logic [63:0]  l2;
      logic [63:0]  k;
      logic [63:0]  m;
      logic [63:0]  e;
      tbl = '0;
      for (x = 9'd1; x < 9'd256; x = x + 9'd1) begin
         e = 64'd0;
         for (int i = 1; i < 8; i++) begin
            if ((x >> i) != 9'd0) begin
               e = 64'(i);
            end
         end
         m = (64'(x) << (64'd7 - e)) & 64'h7F;
         k = m << (LOG_INDEX_BITS - 7);
         z = (64'd1 << 30) + (k << (30 - LOG_INDEX_BITS));
         l2 = 64'd0;
         for (int b = 1; b <= 20; b++) begin
            z = (z * z) >> 30;
            if (z >= (64'd2 << 30)) begin
               z = z >> 1;
               l2 = l2 | (64'd1 << (20 - b));
            end
         end
         tbl[x[7:0]] = 15'(e * LN2_Q12 + ((l2 * LN2_Q30 + (64'd1 << 37)) >> 38));
      end
      return tbl;
   endfunction

   localparam ln_table_type LN_TABLE = build_ln_table();

endpackage

@@ design/lci_color_correct.sv @@
module lci_color_correct (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       red,
   input  logic [7:0]       green,
   input  logic [7:0]       blue,
   input  lci_pkg::cfg_type cfg,
   output logic             out_valid,
   output logic [7:0]       red_out,
   output logic [7:0]       green_out,
   output logic [7:0]       blue_out
);
   import lci_pkg::*;

   acc_type    r_ext, g_ext, b_ext;
   acc_type    acc_r_in, acc_g_in, acc_b_in;
   acc_type    acc_r_ff, acc_g_ff, acc_b_ff;
   logic       valid_acc_ff, valid_ch_ff;
   logic [7:0] ch_r_in, ch_g_in, ch_b_in;
   logic [7:0] ch_r_ff, ch_g_ff, ch_b_ff;

   function automatic logic [7:0] clamp_channel(acc_type acc, logic [7:0] lo, logic [7:0] hi);
      acc_type    rounded;
      logic [8:0] v;
      logic [7:0] c;
      rounded = acc + ACC_ROUND;
      v = (acc > 24'sd0) ? rounded[22:14] : 9'd0;
      if (v > {1'b0, hi}) begin
         c = hi;
      end else if (v < {1'b0, lo}) begin
         c = lo;
      end else begin
         c = v[7:0];
      end
      if (c == 8'd0) begin
         c = 8'd1;
      end
      return c;
   endfunction

   assign r_ext = {16'b0, red};
   assign g_ext = {16'b0, green};
   assign b_ext = {16'b0, blue};

   // every row uses the uncorrected channels
   assign acc_r_in = M_RR * r_ext - M_RG * g_ext - M_RB * b_ext;
   assign acc_g_in = M_GG * g_ext - M_GR * r_ext - M_GB * b_ext;
   assign acc_b_in = M_BR * r_ext - M_BG * g_ext + M_BB * b_ext;

   assign ch_r_in = clamp_channel(acc_r_ff, cfg.clamp_floor, cfg.clamp_ceiling);
   assign ch_g_in = clamp_channel(acc_g_ff, cfg.clamp_floor, cfg.clamp_ceiling);
   assign ch_b_in = clamp_channel(acc_b_ff, cfg.clamp_floor, cfg.clamp_ceiling);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_acc_ff <= 1'b0;
         valid_ch_ff  <= 1'b0;
      end else begin
         valid_acc_ff <= in_valid;
         valid_ch_ff  <= valid_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_r_ff <= acc_r_in;
      acc_g_ff <= acc_g_in;
      acc_b_ff <= acc_b_in;
      ch_r_ff  <= ch_r_in;
      ch_g_ff  <= ch_g_in;
      ch_b_ff  <= ch_b_in;
   end

   assign out_valid = valid_ch_ff;
   assign red_out   = ch_r_ff;
   assign green_out = ch_g_ff;
   assign blue_out  = ch_b_ff;

endmodule

@@ design/lci_log_chroma.sv @@
module lci_log_chroma (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       red,
   input  logic [7:0]       green,
   input  logic [7:0]       blue,
   output logic             out_valid,
   output lci_pkg::chi_type chi_r3,
   output lci_pkg::chi_type chi_b3
);
   import lci_pkg::*;

   ln_word_type ln_r_ff, ln_g_ff, ln_b_ff;
   chi_type     lr_x, lg_x, lb_x;
   chi_type     chi_r3_in, chi_b3_in;
   chi_type     chi_r3_ff, chi_b3_ff;
   logic        valid_ln_ff, valid_chi_ff;

   assign lr_x = {2'b0, ln_r_ff};
   assign lg_x = {2'b0, ln_g_ff};
   assign lb_x = {2'b0, ln_b_ff};

   // three times (log minus mean log)
   assign chi_r3_in = (lr_x <<< 1) - lg_x - lb_x;
   assign chi_b3_in = (lb_x <<< 1) - lr_x - lg_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ln_ff  <= 1'b0;
         valid_chi_ff <= 1'b0;
      end else begin
         valid_ln_ff  <= in_valid;
         valid_chi_ff <= valid_ln_ff;
      end
   end

   always_ff @(posedge clock) begin
      ln_r_ff   <= LN_TABLE[red];
      ln_g_ff   <= LN_TABLE[green];
      ln_b_ff   <= LN_TABLE[blue];
      chi_r3_ff <= chi_r3_in;
      chi_b3_ff <= chi_b3_in;
   end

   assign out_valid = valid_chi_ff;
   assign chi_r3    = chi_r3_ff;
   assign chi_b3    = chi_b3_ff;

endmodule

@@ design/lci_project.sv @@
module lci_project (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  lci_pkg::chi_type chi_r3,
   input  lci_pkg::chi_type chi_b3,
   input  lci_pkg::cfg_type cfg,
   output logic             out_valid,
   output logic [7:0]       value
);
   import lci_pkg::*;

   localparam logic [9:0]  SAT_LIMIT = 10'd768;
   localparam logic [19:0] RECIP3    = 20'd683;

   proj_type    chi_r_ext, chi_b_ext, cos_ext, sin_ext;
   proj_type    prod_c_ff, prod_s_ff, proj_ff;
   scaled_type  proj_wide, gain_wide, scaled_ff, off_term, total;
   logic [9:0]  off3;
   logic        neg_ff, sat_ff;
   logic [9:0]  quot_ff;
   logic [19:0] recip;
   logic [7:0]  value_in, value_ff;
   logic [4:0]  valid_ff;

   assign chi_r_ext = proj_type'(chi_r3);
   assign chi_b_ext = proj_type'(chi_b3);
   assign cos_ext   = proj_type'(cfg.proj_cos);
   assign sin_ext   = proj_type'(cfg.proj_sin);

   assign proj_wide = scaled_type'(proj_ff);
   assign gain_wide = {34'b0, cfg.stretch_gain};

   // offset times 3 * 2^26
   assign off3     = {2'b0, cfg.stretch_offset} + {1'b0, cfg.stretch_offset, 1'b0};
   assign off_term = {6'b0, off3, 26'b0};
   assign total    = scaled_ff + off_term;

   // quotient below 768 divided by 3 through 683 / 2^11
   assign recip = {10'b0, quot_ff} * RECIP3;

   always_comb begin
      if (neg_ff) begin
         value_in = 8'd0;
      end else if (sat_ff) begin
         value_in = 8'd255;
      end else begin
         value_in = recip[18:11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      prod_c_ff <= chi_b_ext * cos_ext;
      prod_s_ff <= chi_r_ext * sin_ext;
      proj_ff   <= prod_c_ff + prod_s_ff;
      scaled_ff <= proj_wide * gain_wide;
      neg_ff    <= total[41];
      sat_ff    <= (total[40:26] >= {5'b0, SAT_LIMIT});
      quot_ff   <= total[35:26];
      value_ff  <= value_in;
   end

   assign out_valid = valid_ff[4];
   assign value     = value_ff;

endmodule

@@ design/log_chroma_invariant_pixel.sv @@
// Illumination-invariant grey value, one RGB pixel per beat. A pixel is taken
// at every clock edge with start high and busy low; busy is high only while
// reset is held, so a new pixel may be offered every cycle. Each pixel gives
// exactly one result, in order, with rsp_valid high for a single cycle, from
// a nine-stage pipeline (matrix, clamp, log lookup, chromaticity, two
// projection products, sum, gain, offset and scale, divide by three with
// saturation). The result cannot be held back, so the receiver must take it
// on the strobe. Configuration registers are read live by the pipeline:
// write them only when no pixel is in flight.
module log_chroma_invariant_pixel (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [7:0]                      req_red_in,
   input  logic [7:0]                      req_green_in,
   input  logic [7:0]                      req_blue_in,
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_invariant_value,
   input  logic                            csr_write,
   input  logic [lci_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lci_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lci_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic       cc_valid;
   logic [7:0] cc_red, cc_green, cc_blue;
   logic       lc_valid;
   chi_type    lc_chi_r3, lc_chi_b3;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PROJ_COS:       cfg_in.proj_cos       = coef_type'(csr_data);
            CSR_PROJ_SIN:       cfg_in.proj_sin       = coef_type'(csr_data);
            CSR_STRETCH_GAIN:   cfg_in.stretch_gain   = csr_data[7:0];
            CSR_STRETCH_OFFSET: cfg_in.stretch_offset = csr_data[7:0];
            CSR_CLAMP_FLOOR:    cfg_in.clamp_floor    = csr_data[7:0];
            CSR_CLAMP_CEILING:  cfg_in.clamp_ceiling  = csr_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.proj_cos       <= RESET_PROJ_COS;
         cfg_ff.proj_sin       <= RESET_PROJ_SIN;
         cfg_ff.stretch_gain   <= RESET_STRETCH_GAIN;
         cfg_ff.stretch_offset <= RESET_STRETCH_OFFSET;
         cfg_ff.clamp_floor    <= RESET_CLAMP_FLOOR;
         cfg_ff.clamp_ceiling  <= RESET_CLAMP_CEILING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lci_color_correct u_color_correct (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .cfg       (cfg_ff),
      .out_valid (cc_valid),
      .red_out   (cc_red),
      .green_out (cc_green),
      .blue_out  (cc_blue)
   );

   lci_log_chroma u_log_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cc_valid),
      .red       (cc_red),
      .green     (cc_green),
      .blue      (cc_blue),
      .out_valid (lc_valid),
      .chi_r3    (lc_chi_r3),
      .chi_b3    (lc_chi_b3)
   );

   lci_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lc_valid),
      .chi_r3    (lc_chi_r3),
      .chi_b3    (lc_chi_b3),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .value     (rsp_invariant_value)
   );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import lci_pkg::*;

   localparam int     CLOCK_HALF    = 6;
   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     DRAIN_LIMIT   = 40;
   localparam int     TAIL_CYCLES   = 12;
   localparam int     RANDOM_PHASES = 6;
   localparam int     PHASE_PIXELS  = 192;
   localparam int     ROM_BITS      = 10;
   localparam int     INTERP_BITS   = 15 - ROM_BITS;
   localparam longint LN2_STEP      = 2839;
   localparam longint unsigned LN2_FINE = 64'd744261118;
   localparam longint SCALE_UNIT    = 201326592;   // 3 * 2^26

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] invariant;
   } pixel_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [7:0]            req_red_in = '0;
   logic [7:0]            req_green_in = '0;
   logic [7:0]            req_blue_in = '0;
   logic                  rsp_valid;
   logic [7:0]            rsp_invariant_value;
   logic                  csr_write = 1'b0;
   csr_index_type         csr_index = CSR_PROJ_COS;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type       settings;
   pixel_result_t pending_invariants[$];
   int            fail_count = 0;
   int            checked_count = 0;
   int            settings_count = 1;
   bit            gaps_on = 1'b0;
   int            burst_left = 0;

   always #CLOCK_HALF clock = ~clock;

   log_chroma_invariant_pixel i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_red_in          (req_red_in),
      .req_green_in        (req_green_in),
      .req_blue_in         (req_blue_in),
      .rsp_valid           (rsp_valid),
      .rsp_invariant_value (rsp_invariant_value),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // ln(1 + k/2^ROM_BITS) in Q4.12, log2 by repeated squaring
   function automatic longint unsigned log_rom_entry(int unsigned k);
      longint unsigned z;
      longint unsigned l2;
      if (k == (1 << ROM_BITS)) begin
         l2 = 64'd1 << 20;
      end else begin
         z = (64'd1 << 30) + (64'(k) << (30 - ROM_BITS));
         l2 = 0;
         for (int i = 1; i <= 20; i++) begin
            z = (z * z) >> 30;
            if (z >= (64'd2 << 30)) begin
               z = z >> 1;
               l2 = l2 | (64'd1 << (20 - i));
            end
         end
      end
      return (l2 * LN2_FINE + (64'd1 << 37)) >> 38;
   endfunction

   function automatic longint ln_q12(int unsigned x);
      int unsigned     e;
      int unsigned     frac;
      int unsigned     idx;
      int unsigned     rem;
      longint unsigned lo;
      longint unsigned hi;
      e = 0;
      while (e < 7 && (x >> (e + 1)) != 0) begin
         e++;
      end
      frac = (x << (15 - e)) & 32'h7FFF;
      idx = frac >> INTERP_BITS;
      rem = frac & ((1 << INTERP_BITS) - 1);
      lo = log_rom_entry(idx);
      hi = log_rom_entry(idx + 1);
      return longint'(e * LN2_STEP + lo + (((hi - lo) * rem) >> INTERP_BITS));
   endfunction

   function automatic int unsigned correct_channel(longint acc);
      int unsigned v;
      v = 0;
      if (acc > 0) begin
         v = int'((acc + 8192) >>> 14);
      end
      if (v > settings.clamp_ceiling) begin
         v = settings.clamp_ceiling;
      end else if (v < settings.clamp_floor) begin
         v = settings.clamp_floor;
      end
      if (v == 0) begin
         v = 1;
      end
      return v;
   endfunction

   function automatic logic [7:0] predict_invariant(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b);
      longint ri, gi, bi, lr, lg, lb, log_sum, chi_r3, chi_b3, proj3, total, q;
      ri = longint'(r);
      gi = longint'(g);
      bi = longint'(b);
      // every row works on the uncorrected channels
      lr = ln_q12(correct_channel(16364 * ri - 1096 * gi - 2 * bi));
      lg = ln_q12(correct_channel(-814 * ri + 16197 * gi - 2 * bi));
      lb = ln_q12(correct_channel(70 * ri - 2205 * gi + 16384 * bi));
      log_sum = lr + lg + lb;
      chi_r3 = 3 * lr - log_sum;
      chi_b3 = 3 * lb - log_sum;
      proj3 = chi_b3 * longint'(settings.proj_cos) + chi_r3 * longint'(settings.proj_sin);
      total = longint'(settings.stretch_gain) * proj3
            + longint'(settings.stretch_offset) * SCALE_UNIT;
      if (total < 0) begin
         q = 0;
      end else begin
         q = total / SCALE_UNIT;
         if (q > 255) begin
            q = 255;
         end
      end
      return q[7:0];
   endfunction

   function automatic cfg_type make_settings(int cos_v, int sin_v, int gain_v, int offset_v,
                                             int floor_v, int ceiling_v);
      cfg_type s;
      s.proj_cos       = 15'(cos_v);
      s.proj_sin       = 15'(sin_v);
      s.stretch_gain   = 8'(gain_v);
      s.stretch_offset = 8'(offset_v);
      s.clamp_floor    = 8'(floor_v);
      s.clamp_ceiling  = 8'(ceiling_v);
      return s;
   endfunction

   always @(posedge clock) begin : check_results
      pixel_result_t pending;
      if (rsp_valid === 1'b1) begin
         if (pending_invariants.size() == 0) begin
            $error("invariant_value beat with no pixel pending: expected none, actual %0d",
                   rsp_invariant_value);
            fail_count++;
         end else begin
            pending = pending_invariants.pop_front();
            checked_count++;
            if (rsp_invariant_value !== pending.invariant) begin
               $error("invariant_value for pixel (%0d,%0d,%0d): expected %0d, actual %0d",
                      pending.red, pending.green, pending.blue, pending.invariant,
                      rsp_invariant_value);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   task automatic drive_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      pixel_result_t item;
      if (gaps_on && burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      start <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      do @(posedge clock); while (busy !== 1'b0);
      item.red = r;
      item.green = g;
      item.blue = b;
      item.invariant = predict_invariant(r, g, b);
      pending_invariants.push_back(item);
   endtask

   task automatic settle_results();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (pending_invariants.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_invariants.size() != 0) begin
         $error("%0d invariant_value results never arrived", pending_invariants.size());
         fail_count++;
         pending_invariants.delete();
      end
   endtask

   task automatic apply_settings(input cfg_type s);
      settle_results();
      csr_write <= 1'b1;
      csr_index <= CSR_PROJ_COS;
      csr_data <= 15'(s.proj_cos);
      @(posedge clock);
      csr_index <= CSR_PROJ_SIN;
      csr_data <= 15'(s.proj_sin);
      @(posedge clock);
      csr_index <= CSR_STRETCH_GAIN;
      csr_data <= 15'(s.stretch_gain);
      @(posedge clock);
      csr_index <= CSR_STRETCH_OFFSET;
      csr_data <= 15'(s.stretch_offset);
      @(posedge clock);
      csr_index <= CSR_CLAMP_FLOOR;
      csr_data <= 15'(s.clamp_floor);
      @(posedge clock);
      csr_index <= CSR_CLAMP_CEILING;
      csr_data <= 15'(s.clamp_ceiling);
      @(posedge clock);
      csr_write <= 1'b0;
      settings = s;
      settings_count++;
   endtask

   task automatic test_reset_defaults();
      gaps_on = 1'b0;
      drive_pixel(8'd0, 8'd0, 8'd0);
      drive_pixel(8'd255, 8'd255, 8'd255);
      drive_pixel(8'd255, 8'd0, 8'd0);
      drive_pixel(8'd0, 8'd255, 8'd0);
      drive_pixel(8'd0, 8'd0, 8'd255);
      drive_pixel(8'd1, 8'd1, 8'd1);
      drive_pixel(8'd10, 8'd10, 8'd10);
      drive_pixel(8'd246, 8'd246, 8'd246);
   endtask

   // corrected sums that land exactly on .5 must round up
   task automatic test_rounding_ties();
      longint     base;
      longint     need;
      bit         found[3];
      logic [7:0] tie_red[3];
      logic [7:0] tie_green[3];
      logic [7:0] tie_blue[3];
      found = '{1'b0, 1'b0, 1'b0};
      for (int r = 0; r < 256; r++) begin
         for (int g = 0; g < 256; g++) begin
            base = 16364 * r - 1096 * g;
            need = ((base - 8192) % 16384 + 16384) % 16384;
            if (!found[0] && need % 2 == 0 && need / 2 < 256 && base - need > 0) begin
               found[0] = 1'b1;
               tie_red[0] = 8'(r);
               tie_green[0] = 8'(g);
               tie_blue[0] = 8'(need / 2);
            end
            base = -814 * r + 16197 * g;
            need = ((base - 8192) % 16384 + 16384) % 16384;
            if (!found[1] && need % 2 == 0 && need / 2 < 256 && base - need > 0) begin
               found[1] = 1'b1;
               tie_red[1] = 8'(r);
               tie_green[1] = 8'(g);
               tie_blue[1] = 8'(need / 2);
            end
            base = 70 * r - 2205 * g;
            if (!found[2] && ((base % 16384) + 16384) % 16384 == 8192) begin
               found[2] = 1'b1;
               tie_red[2] = 8'(r);
               tie_green[2] = 8'(g);
               tie_blue[2] = 8'd255;
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (found[i]) begin
            drive_pixel(tie_red[i], tie_green[i], tie_blue[i]);
         end
      end
   endtask

   task automatic test_output_saturation();
      apply_settings(make_settings(-16384, 16383, 255, 0, 10, 245));
      drive_pixel(8'd255, 8'd0, 8'd0);
      drive_pixel(8'd0, 8'd0, 8'd255);
      apply_settings(make_settings(16383, -16384, 255, 255, 10, 245));
      drive_pixel(8'd255, 8'd0, 8'd0);
      drive_pixel(8'd0, 8'd0, 8'd255);
      apply_settings(make_settings(16383, 16383, 0, 255, 10, 245));
      drive_pixel(8'd200, 8'd30, 8'd90);
      apply_settings(make_settings(-16384, -16384, 0, 0, 10, 245));
      drive_pixel(8'd200, 8'd30, 8'd90);
   endtask

   task automatic test_clamp_window();
      // ceiling below floor: ceiling wins above it, floor at or below it
      apply_settings(make_settings(-10917, 12218, 32, 128, 255, 1));
      drive_pixel(8'd0, 8'd0, 8'd0);
      drive_pixel(8'd255, 8'd3, 8'd128);
      apply_settings(make_settings(-10917, 12218, 32, 128, 128, 128));
      drive_pixel(8'd255, 8'd255, 8'd255);
      drive_pixel(8'd1, 8'd200, 8'd40);
      apply_settings(make_settings(-10917, 12218, 32, 128, 1, 255));
      drive_pixel(8'd0, 8'd255, 8'd0);
      drive_pixel(8'd1, 8'd0, 8'd200);
   endtask

   task automatic test_random_settings();
      int         cos_v, sin_v, floor_v, ceiling_v;
      logic [7:0] base;
      logic [7:0] r, g, b;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            apply_settings(make_settings(-10917, 12218, 32, 128, 10, 245));
         end else begin
            cos_v = int'($urandom_range(0, 32767)) - 16384;
            sin_v = int'($urandom_range(0, 32767)) - 16384;
            if ($urandom_range(0, 3) == 0) begin
               floor_v = $urandom_range(1, 255);
               ceiling_v = $urandom_range(1, 255);
            end else begin
               floor_v = $urandom_range(1, 60);
               ceiling_v = $urandom_range(180, 255);
            end
            apply_settings(make_settings(cos_v, sin_v, $urandom_range(0, 255),
                                         $urandom_range(0, 255), floor_v, ceiling_v));
         end
         gaps_on = (p % 3 != 2);
         burst_left = 0;
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            case ($urandom_range(0, 7))
               0: begin
                  r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               end
               1, 2: begin
                  base = 8'($urandom_range(0, 255));
                  r = base ^ 8'($urandom_range(0, 15));
                  g = base ^ 8'($urandom_range(0, 15));
                  b = base ^ 8'($urandom_range(0, 15));
               end
               default: begin
                  r = 8'($urandom_range(0, 255));
                  g = 8'($urandom_range(0, 255));
                  b = 8'($urandom_range(0, 255));
               end
            endcase
            drive_pixel(r, g, b);
         end
      end
   endtask

   initial begin
      settings = make_settings(-10917, 12218, 32, 128, 10, 245);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_rounding_ties();
      test_output_saturation();
      test_clamp_window();
      test_random_settings();
      settle_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d pixel results under %0d register settings,", checked_count,
               settings_count);
      $display("random phases ran both with and without gaps between input beats");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/lci_pkg.sv
design/lci_color_correct.sv
design/lci_log_chroma.sv
design/lci_project.sv
design/log_chroma_invariant_pixel.sv
bench/tb_top.sv
